// ===== hdl/ssd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Sobel stereo descriptor block.
package ssd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 2048;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int BORDER       = 3;
    localparam int GRAD_ROWS    = 8;
    localparam int GRAD_SLOT_W  = $clog2(GRAD_ROWS);
    localparam int SAT_OFFSET   = 128;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } ssd_reg_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } ssd_in_t;

    typedef struct packed {
        logic [63:0]      descriptor_low;
        logic [63:0]      descriptor_high;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             frame_end;
    } ssd_out_t;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       pixel;
        logic             emit;
        logic             nonzero;
        logic             frame_end;
    } ssd_req_t;

    typedef struct packed {
        logic [7:0] dx;
        logic [7:0] dy;
    } ssd_grad_t;

endpackage

// ===== hdl/sobel_stereo_descriptor.sv =====
`timescale 1ns / 1ps
// A descriptor passes s1_reg and then the result queue. Throughput: one pixel per
// clock while sample_stall is low, set by one read-modify-write per cycle on each
// line memory (pixel rows and gradient rows, one column word per access).
// Reset: position counters, pipeline and result queue clear; size registers go to
// 640 x 480. Line memories keep their contents and need no clearing pass.
module sobel_stereo_descriptor
    import ssd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  ssd_reg_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  ssd_in_t               sample,
    output logic                  desc_valid,
    input  logic                  desc_stall,
    output ssd_out_t              desc
);

    logic [WIDTH_REG_W-1:0]  image_width_reg;
    logic [HEIGHT_REG_W-1:0] image_height_reg;
    logic [WIDTH_REG_W-1:0]  width_eff;
    logic [HEIGHT_REG_W-1:0] height_eff;
    logic [ROW_W-1:0]        row_count_reg;
    logic [ROW_W-1:0]        row_count_next;
    logic [COL_W-1:0]        col_count_reg;
    logic [COL_W-1:0]        col_count_next;
    logic [ROW_W-1:0]        row_cur;
    logic [COL_W-1:0]        col_cur;
    logic [COL_W:0]          col_inc;
    logic [ROW_W:0]          row_inc;
    logic                    accept;
    ssd_req_t                req;
    ssd_req_t                s1_reg;
    ssd_grad_t               grad;
    ssd_out_t                item;
    logic [QUEUE_CW-1:0]     q_count;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (q_count + QUEUE_CW'(s1_reg.valid)) >= QUEUE_CW'(QUEUE_DEPTH);
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        width_eff = image_width_reg;
        if (image_width_reg == '0)
            width_eff = WIDTH_REG_W'(1);
        else if (image_width_reg > WIDTH_REG_W'(MAX_WIDTH))
            width_eff = WIDTH_REG_W'(MAX_WIDTH);

        height_eff = image_height_reg;
        if (image_height_reg == '0)
            height_eff = HEIGHT_REG_W'(1);
        else if (image_height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            height_eff = HEIGHT_REG_W'(MAX_HEIGHT);

        row_cur = sample.frame_start ? '0 : row_count_reg;
        col_cur = sample.frame_start ? '0 : col_count_reg;
        col_inc = {1'b0, col_cur} + (COL_W + 1)'(1);
        row_inc = {1'b0, row_cur} + (ROW_W + 1)'(1);

        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (accept)
        begin
            if (col_inc >= width_eff)
            begin
                col_count_next = '0;
                row_count_next = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_count_next = col_inc[COL_W-1:0];
                row_count_next = row_cur;
            end
        end

        req.valid     = accept;
        req.row       = row_cur;
        req.col       = col_cur;
        req.pixel     = sample.pixel;
        req.emit      = (row_cur >= ROW_W'(BORDER)) && (col_cur >= COL_W'(BORDER));
        req.nonzero   = (row_cur >= ROW_W'(2 * BORDER)) && (col_cur >= COL_W'(2 * BORDER));
        req.frame_end = ({1'b0, row_cur} == height_eff - HEIGHT_REG_W'(1))
                     && ({1'b0, col_cur} == width_eff - WIDTH_REG_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_reg        <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            s1_reg        <= req;
        end
    end

    ssd_pix_grad u_pix_grad (
        .clk  (clk),
        .req  (req),
        .s1   (s1_reg),
        .grad (grad)
    );

    ssd_grad_taps u_grad_taps (
        .clk  (clk),
        .req  (req),
        .s1   (s1_reg),
        .grad (grad),
        .item (item)
    );

    ssd_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_reg.valid && s1_reg.emit),
        .push_item  (item),
        .desc_stall (desc_stall),
        .desc_valid (desc_valid),
        .desc       (desc),
        .count      (q_count)
    );

endmodule

// ===== hdl/ssd_pix_grad.sv =====
`timescale 1ns / 1ps
// Pixel line memory, 3x3 window and saturated Sobel gradient.
module ssd_pix_grad
    import ssd_pkg::*;
(
    input  logic      clk,
    input  ssd_req_t  req,
    input  ssd_req_t  s1,
    output ssd_grad_t grad
);

    logic [15:0] pix_mem [MAX_WIDTH];
    logic [15:0] pix_rdata_reg;
    logic [15:0] last_word_reg;
    logic        fwd_reg;
    logic [15:0] word;
    logic [15:0] wword;
    logic [7:0]  win1_reg [3];
    logic [7:0]  win2_reg [3];
    logic [7:0]  col_new [3];
    logic signed [11:0] gx;
    logic signed [11:0] gy;

    function automatic logic signed [11:0] ext12(input logic [7:0] b);
        ext12 = $signed({4'b0000, b});
    endfunction

    function automatic logic [7:0] sat8(input logic signed [11:0] g);
        logic signed [11:0] s;
        begin
            s = g + $signed(12'(SAT_OFFSET));
            if (s < 0)
                sat8 = 8'd0;
            else if (s > 12'sd255)
                sat8 = 8'd255;
            else
                sat8 = s[7:0];
        end
    endfunction

    always_comb
    begin
        word = fwd_reg ? last_word_reg : pix_rdata_reg;
        if (s1.row[0])
        begin
            col_new[0] = word[15:8];
            col_new[1] = word[7:0];
            wword      = {s1.pixel, word[7:0]};
        end
        else
        begin
            col_new[0] = word[7:0];
            col_new[1] = word[15:8];
            wword      = {word[15:8], s1.pixel};
        end
        col_new[2] = s1.pixel;

        gx = (ext12(col_new[0]) - ext12(win1_reg[0]))
           + ((ext12(col_new[1]) - ext12(win1_reg[1])) <<< 1)
           + (ext12(col_new[2]) - ext12(win1_reg[2]));
        gy = (ext12(win1_reg[2]) + (ext12(win2_reg[2]) <<< 1) + ext12(col_new[2]))
           - (ext12(win1_reg[0]) + (ext12(win2_reg[0]) <<< 1) + ext12(col_new[0]));

        grad.dx = sat8(gx);
        grad.dy = sat8(gy);
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            pix_rdata_reg <= pix_mem[req.col];
        end
        if (s1.valid)
        begin
            pix_mem[s1.col] <= wword;
        end
    end

    // forward the word just written when the next request hits the same column
    always_ff @(posedge clk)
    begin
        fwd_reg <= s1.valid && (s1.col == req.col);
        if (s1.valid)
        begin
            last_word_reg <= wword;
            for (int k = 0; k < 3; k++)
            begin
                win1_reg[k] <= win2_reg[k];
                win2_reg[k] <= col_new[k];
            end
        end
    end

endmodule

// ===== hdl/ssd_grad_taps.sv =====
`timescale 1ns / 1ps
// Gradient line memory, tap history and descriptor assembly.
module ssd_grad_taps
    import ssd_pkg::*;
(
    input  logic      clk,
    input  ssd_req_t  req,
    input  ssd_req_t  s1,
    input  ssd_grad_t grad,
    output ssd_out_t  item
);

    localparam int WORD_W = 2 * GRAD_ROWS * 8;

    typedef struct packed {
        logic [7:0] dx_a;
        logic [7:0] dx_b;
        logic [7:0] dx_c;
        logic [7:0] dx_d;
        logic [7:0] dy_b;
        logic [7:0] dy_c;
        logic [7:0] dy_d;
    } ssd_col_t;

    logic [WORD_W-1:0]      grad_mem [MAX_WIDTH];
    logic [WORD_W-1:0]      rdata_reg;
    logic [WORD_W-1:0]      wword;
    logic [COL_W-1:0]       raddr;
    logic [COL_W-1:0]       waddr;
    logic [GRAD_SLOT_W-1:0] row_lsb;
    logic [GRAD_SLOT_W-1:0] slot_a;
    logic [GRAD_SLOT_W-1:0] slot_b;
    logic [GRAD_SLOT_W-1:0] slot_c;
    logic [GRAD_SLOT_W-1:0] slot_d;
    logic [GRAD_SLOT_W-1:0] slot_w;
    ssd_col_t               cur;
    ssd_col_t               hist_reg [4];
    logic [7:0]             dxe1_reg;
    logic [7:0]             dxe2_reg;
    logic [7:0]             tap [16];

    function automatic logic [7:0] dx_at(input logic [WORD_W-1:0] w,
                                         input logic [GRAD_SLOT_W-1:0] s);
        dx_at = w[{1'b0, s, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] dy_at(input logic [WORD_W-1:0] w,
                                         input logic [GRAD_SLOT_W-1:0] s);
        dy_at = w[{1'b1, s, 3'b000} +: 8];
    endfunction

    assign raddr = req.col - COL_W'(1);
    assign waddr = s1.col - COL_W'(1);

    always_comb
    begin
        row_lsb = s1.row[GRAD_SLOT_W-1:0];
        slot_a  = row_lsb - GRAD_SLOT_W'(5);
        slot_b  = row_lsb - GRAD_SLOT_W'(4);
        slot_c  = row_lsb - GRAD_SLOT_W'(3);
        slot_d  = row_lsb - GRAD_SLOT_W'(2);
        slot_w  = row_lsb - GRAD_SLOT_W'(1);

        wword = rdata_reg;
        wword[{1'b0, slot_w, 3'b000} +: 8] = grad.dx;
        wword[{1'b1, slot_w, 3'b000} +: 8] = grad.dy;

        cur.dx_a = dx_at(rdata_reg, slot_a);
        cur.dx_b = dx_at(rdata_reg, slot_b);
        cur.dx_c = dx_at(rdata_reg, slot_c);
        cur.dx_d = dx_at(rdata_reg, slot_d);
        cur.dy_b = dy_at(rdata_reg, slot_b);
        cur.dy_c = dy_at(rdata_reg, slot_c);
        cur.dy_d = dy_at(rdata_reg, slot_d);

        tap[0]  = hist_reg[1].dx_a;
        tap[1]  = hist_reg[3].dx_b;
        tap[2]  = hist_reg[1].dx_b;
        tap[3]  = cur.dx_b;
        tap[4]  = hist_reg[2].dx_c;
        tap[5]  = hist_reg[1].dx_c;
        tap[6]  = hist_reg[1].dx_c;
        tap[7]  = hist_reg[0].dx_c;
        tap[8]  = hist_reg[3].dx_d;
        tap[9]  = hist_reg[1].dx_d;
        tap[10] = cur.dx_d;
        tap[11] = dxe2_reg;
        tap[12] = hist_reg[1].dy_b;
        tap[13] = hist_reg[2].dy_c;
        tap[14] = hist_reg[0].dy_c;
        tap[15] = hist_reg[1].dy_d;

        if (s1.nonzero)
        begin
            item.descriptor_low  = {tap[7], tap[6], tap[5], tap[4],
                                    tap[3], tap[2], tap[1], tap[0]};
            item.descriptor_high = {tap[15], tap[14], tap[13], tap[12],
                                    tap[11], tap[10], tap[9], tap[8]};
        end
        else
        begin
            item.descriptor_low  = '0;
            item.descriptor_high = '0;
        end
        item.center_row = s1.row - ROW_W'(BORDER);
        item.center_col = s1.col - COL_W'(BORDER);
        item.frame_end  = s1.frame_end;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rdata_reg <= grad_mem[raddr];
        end
        if (s1.valid && (s1.col != '0))
        begin
            grad_mem[waddr] <= wword;
        end
    end

    // advance the column history once per request
    always_ff @(posedge clk)
    begin
        if (s1.valid)
        begin
            hist_reg[0] <= cur;
            hist_reg[1] <= hist_reg[0];
            hist_reg[2] <= hist_reg[1];
            hist_reg[3] <= hist_reg[2];
            dxe1_reg    <= grad.dx;
            dxe2_reg    <= dxe1_reg;
        end
    end

endmodule

// ===== hdl/ssd_out_queue.sv =====
`timescale 1ns / 1ps
// Result queue between the compute stage and the output channel.
module ssd_out_queue
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ssd_out_t            push_item,
    input  logic                desc_stall,
    output logic                desc_valid,
    output ssd_out_t            desc,
    output logic [QUEUE_CW-1:0] count
);

    ssd_out_t            q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                pop;

    assign desc_valid = (count_reg != '0);
    assign desc       = q_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign pop        = desc_valid && !desc_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/ssd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the Sobel stereo descriptor block, with its bind.
module ssd_checker
    import ssd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     sample_valid,
    input logic     sample_stall,
    input logic     desc_valid,
    input logic     desc_stall,
    input ssd_out_t desc
);

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && desc_stall |=> desc_valid)
        else $error("descriptor request dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && desc_stall |=> $stable(desc))
        else $error("descriptor payload changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && (desc.center_row < ROW_W'(BORDER) || desc.center_col < COL_W'(BORDER))
        |-> (desc.descriptor_low == '0 && desc.descriptor_high == '0))
        else $error("border descriptor is not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(desc_valid) |-> $past(sample_valid && !sample_stall, 2))
        else $error("descriptor appeared without a pixel request two cycles earlier");

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> desc_valid)
        else $error("pixel stalled with no descriptor pending");

endmodule

bind sobel_stereo_descriptor ssd_checker u_ssd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .desc_valid   (desc_valid),
    .desc_stall   (desc_stall),
    .desc         (desc)
);
